### rtl/nls_pkg.sv
// Package for the numeric literal scanner: scan phase codes, character codes,
// the phase/flag group and the result word type. No dependencies.
package nls_pkg;

  localparam int unsigned COUNT_LIMIT_DEF = 255;

  localparam logic [2:0] PH_SPACE   = 3'd0;
  localparam logic [2:0] PH_SIGN    = 3'd1;
  localparam logic [2:0] PH_INT     = 3'd2;
  localparam logic [2:0] PH_DOT     = 3'd3;
  localparam logic [2:0] PH_FRAC    = 3'd4;
  localparam logic [2:0] PH_EXPSIGN = 3'd5;
  localparam logic [2:0] PH_EXP     = 3'd6;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_BLANK  = 8'd32;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_EXP_UC = 8'd69;
  localparam logic [7:0] CH_EXP_LC = 8'd101;

  typedef struct packed {
    logic [2:0] phase;
    logic       saw_int;
    logic       saw_frac;
  } flags_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] skipped_spaces;
    logic [7:0] token_length;
  } result_t;

endpackage

### rtl/nls_if.sv
// Valid/ready channel interfaces for the numeric literal scanner.
// Standalone; no package dependency.
interface nls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface nls_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] skipped_spaces;
  logic [7:0] token_length;
  modport source (output valid, output accepted, output skipped_spaces,
                  output token_length, input ready);
  modport sink (input valid, input accepted, input skipped_spaces,
                input token_length, output ready);
endinterface

### rtl/nls_step.sv
// Per-character transition of the scanner: next phase, flags and counters,
// and the result word when the scan decides. Depends on nls_pkg.
module nls_step #(
  parameter int unsigned COUNT_LIMIT = nls_pkg::COUNT_LIMIT_DEF,
  localparam int unsigned CW = $clog2(COUNT_LIMIT + 1)
) (
  input  logic [7:0]      char_code,
  input  logic            end_of_input,
  input  nls_pkg::flags_t flags_i,
  input  logic [CW-1:0]   consumed_i,
  input  logic [CW-1:0]   marked_i,
  input  logic [CW-1:0]   skipped_i,
  output nls_pkg::flags_t flags_o,
  output logic [CW-1:0]   consumed_o,
  output logic [CW-1:0]   marked_o,
  output logic [CW-1:0]   skipped_o,
  output logic            emit_o,
  output nls_pkg::result_t res_o
);

  localparam int unsigned OW = (CW > 8) ? CW : 8;

  logic          is_digit, is_space, is_sign, is_exp, is_dot;
  logic [CW-1:0] cons_inc, skip_inc, fin_len;
  logic          fin, ok;
  logic [OW-1:0] len_ext, skip_ext;

  assign is_digit = (char_code >= nls_pkg::CH_ZERO) && (char_code <= nls_pkg::CH_NINE);
  assign is_space = ((char_code >= nls_pkg::CH_TAB) && (char_code <= nls_pkg::CH_CR)) ||
                    (char_code == nls_pkg::CH_BLANK);
  assign is_sign  = (char_code == nls_pkg::CH_PLUS) || (char_code == nls_pkg::CH_MINUS);
  assign is_exp   = (char_code == nls_pkg::CH_EXP_UC) || (char_code == nls_pkg::CH_EXP_LC);
  assign is_dot   = (char_code == nls_pkg::CH_DOT);

  assign cons_inc = (consumed_i >= CW'(COUNT_LIMIT)) ? CW'(COUNT_LIMIT) : consumed_i + CW'(1);
  assign skip_inc = (skipped_i >= CW'(COUNT_LIMIT)) ? CW'(COUNT_LIMIT) : skipped_i + CW'(1);

  always_comb begin
    flags_o    = flags_i;
    consumed_o = consumed_i;
    marked_o   = marked_i;
    skipped_o  = skipped_i;
    fin        = 1'b0;
    ok         = 1'b0;
    fin_len    = marked_i;
    if (end_of_input) begin
      fin = 1'b1;
    end else begin
      case (flags_i.phase)
        nls_pkg::PH_SIGN: begin
          if (is_digit) begin
            consumed_o       = cons_inc;
            marked_o         = cons_inc;
            flags_o.saw_int  = 1'b1;
            flags_o.phase    = nls_pkg::PH_INT;
          end else if (is_dot) begin
            marked_o      = consumed_i;
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_DOT;
          end else begin
            fin = 1'b1;
          end
        end
        nls_pkg::PH_INT: begin
          if (is_digit) begin
            consumed_o      = cons_inc;
            marked_o        = cons_inc;
            flags_o.saw_int = 1'b1;
          end else if (is_dot) begin
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_DOT;
          end else if (is_exp) begin
            consumed_o    = cons_inc;
            marked_o      = cons_inc;
            flags_o.phase = nls_pkg::PH_EXPSIGN;
          end else begin
            fin = 1'b1;
            ok  = flags_i.saw_int;
          end
        end
        nls_pkg::PH_DOT: begin
          if (is_exp) begin
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_EXPSIGN;
          end else if (is_digit) begin
            consumed_o       = cons_inc;
            flags_o.saw_frac = 1'b1;
            flags_o.phase    = nls_pkg::PH_FRAC;
          end else begin
            // A second dot leaves the end before the first one (ranges).
            fin     = 1'b1;
            ok      = flags_i.saw_int;
            fin_len = is_dot ? marked_i : consumed_i;
          end
        end
        nls_pkg::PH_FRAC: begin
          if (is_digit) begin
            consumed_o       = cons_inc;
            flags_o.saw_frac = 1'b1;
          end else if (is_exp) begin
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_EXPSIGN;
          end else begin
            fin     = 1'b1;
            ok      = flags_i.saw_int | flags_i.saw_frac;
            fin_len = consumed_i;
          end
        end
        nls_pkg::PH_EXPSIGN: begin
          if (is_sign || is_digit) begin
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_EXP;
          end else begin
            fin = 1'b1;
          end
        end
        nls_pkg::PH_EXP: begin
          if (is_digit) begin
            consumed_o = cons_inc;
          end else begin
            fin     = 1'b1;
            ok      = 1'b1;
            fin_len = consumed_i;
          end
        end
        default: begin
          flags_o.phase = nls_pkg::PH_SPACE;
          if (is_space) begin
            skipped_o = skip_inc;
          end else if (is_sign) begin
            marked_o      = consumed_i;
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_SIGN;
          end else if (is_digit) begin
            consumed_o      = cons_inc;
            marked_o        = cons_inc;
            flags_o.saw_int = 1'b1;
            flags_o.phase   = nls_pkg::PH_INT;
          end else if (is_dot) begin
            marked_o      = consumed_i;
            consumed_o    = cons_inc;
            flags_o.phase = nls_pkg::PH_DOT;
          end else begin
            fin = 1'b1;
          end
        end
      endcase
    end
    if (fin) begin
      flags_o    = '0;
      consumed_o = '0;
      marked_o   = '0;
      skipped_o  = '0;
    end
  end

  assign len_ext  = OW'(fin_len);
  assign skip_ext = OW'(skipped_i);

  assign emit_o               = fin;
  assign res_o.accepted       = ok;
  assign res_o.skipped_spaces = skip_ext[7:0];
  assign res_o.token_length   = ok ? len_ext[7:0] : 8'd0;

endmodule

### rtl/numeric_literal_scanner.sv
// A result word is registered when its deciding character is accepted; a two-entry output
// buffer keeps input flowing while a result waits. Throughput: one character word per cycle
// while the skid entry is empty; the scan state register carries one transition per accepted
// character. Reset (synchronous, active low) returns the scan to the whitespace phase with all
// counters cleared and the output buffer empty. Depends on nls_pkg, nls_if and nls_step.
module numeric_literal_scanner #(
  parameter int unsigned COUNT_LIMIT = nls_pkg::COUNT_LIMIT_DEF
) (
  input logic           clk,
  input logic           rst_n,
  nls_in_if.sink        in_ch,
  nls_out_if.source     out_ch
);

  localparam int unsigned CW = $clog2(COUNT_LIMIT + 1);

  nls_pkg::flags_t  flags_r, flags_nxt;
  logic [CW-1:0]    consumed_r, consumed_nxt;
  logic [CW-1:0]    marked_r, marked_nxt;
  logic [CW-1:0]    skipped_r, skipped_nxt;
  logic             emit;
  nls_pkg::result_t res;

  nls_pkg::result_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             accept, push, pop;

  nls_step #(.COUNT_LIMIT(COUNT_LIMIT)) u_step (
    .char_code    (in_ch.char_code),
    .end_of_input (in_ch.end_of_input),
    .flags_i      (flags_r),
    .consumed_i   (consumed_r),
    .marked_i     (marked_r),
    .skipped_i    (skipped_r),
    .flags_o      (flags_nxt),
    .consumed_o   (consumed_nxt),
    .marked_o     (marked_nxt),
    .skipped_o    (skipped_nxt),
    .emit_o       (emit),
    .res_o        (res)
  );

  assign in_ch.ready = ~skid_valid_r;
  assign accept      = in_ch.valid & ~skid_valid_r;
  assign push        = accept & emit;
  assign pop         = out_valid_r & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      consumed_r <= '0;
      marked_r   <= '0;
      skipped_r  <= '0;
    end else if (accept) begin
      flags_r    <= flags_nxt;
      consumed_r <= consumed_nxt;
      marked_r   <= marked_nxt;
      skipped_r  <= skipped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_r.accepted;
  assign out_ch.skipped_spaces = out_r.skipped_spaces;
  assign out_ch.token_length   = out_r.token_length;

endmodule
